@@ sv/bqs_pkg.sv @@
// ----------------------------------------------------------------------------
// bqs_pkg
// Shared types and constants for the beat quantize snap block: table geometry,
// register indexes, snap modes, sequencer states and divider transactions.
// ----------------------------------------------------------------------------
package bqs_pkg;

    // beat table geometry
    localparam int BEAT_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(BEAT_DEPTH);
    localparam int CNT_W      = $clog2(BEAT_DEPTH + 1);

    // field widths
    localparam int TIME_W     = 32;
    localparam int IDX_W      = 12;
    localparam int TEMPO_W    = 16;
    localparam int BCNT_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // divider geometry and grid constants
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 30;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
    localparam int DIFF_W    = TIME_W + 1;
    localparam int SUM_W     = DIV_NUM_W + 1;
    localparam logic [DIV_NUM_W-1:0] PERIOD_NUM2 = DIV_NUM_W'(2 * 503316480);

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SNAP  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANTIZE_ENABLE,
        CFG_TEMPO_BPM,
        CFG_GRID_OFFSET,
        CFG_BEAT_COUNT
    } cfg_reg_t;

    // result modes
    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_NO_TEMPO,
        MODE_GRID,
        MODE_TABLE
    } snap_mode_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S_ADDR,
        ST_S_CMP,
        ST_F_RD1,
        ST_F_RD2,
        ST_F_CMP,
        ST_G_PER,
        ST_G_PWAIT,
        ST_G_QUO,
        ST_G_QWAIT,
        ST_G_SUM,
        ST_DONE
    } bqs_state_t;

    // divider transactions
    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] rem;
    } div_rsp_t;

endpackage

@@ sv/bqs_ram.sv @@
// ----------------------------------------------------------------------------
// bqs_ram
// Generic simple dual port RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/bqs_div.sv @@
// ----------------------------------------------------------------------------
// bqs_div
// Unsigned restoring divider, one quotient bit per cycle. Gives quotient and
// remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module bqs_div
    import bqs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_NUM_W-1:0] work_reg, work_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    // one restoring step
    assign trial = {rem_reg, work_reg[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            work_next = {work_reg[DIV_NUM_W-2:0], fits};
            rem_next  = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = work_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ sv/beat_quantize_snap.sv @@
// ----------------------------------------------------------------------------
// beat_quantize_snap
// Snaps a playback position to the nearest beat, either from a sorted beat
// table held in RAM (binary search) or from a uniform tempo grid.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+---------------------------
//   item     | in        | item_valid / item_stall  | cmd, entry_index,
//            |           |                          | entry_time, position
//   result   | out       | result_valid/result_stall| snapped_position, snap_mode
//   cfg      | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Write items give no result. A snap item with quantize off or no tempo passes
// the position straight to the result; table mode runs a binary search, with
// states S_ADDR and S_CMP per search step around the registered RAM read, and
// grid mode waits twice on the shared bit-serial divider.
// Reset clears the control and configuration registers; table entries are
// undefined until written. A finished result waits in the output register,
// write items are still taken while it waits.
// ----------------------------------------------------------------------------
module beat_quantize_snap
    import bqs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    // item channel
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         cmd,
    input  logic [IDX_W-1:0]             entry_index,
    input  logic signed [TIME_W-1:0]     entry_time,
    input  logic signed [TIME_W-1:0]     position,
    // result channel
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [TIME_W-1:0]     snapped_position,
    output logic [1:0]                   snap_mode,
    // configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    bqs_state_t state_reg, state_next;

    // configuration registers
    logic                     quant_en_reg;
    logic [TEMPO_W-1:0]       tempo_reg;
    logic signed [TIME_W-1:0] offset_reg;
    logic [BCNT_W-1:0]        bcount_reg;

    // working registers
    logic signed [TIME_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [ADDR_W-1:0]        mid_reg, mid_next;
    logic                     single_reg, single_next;
    logic signed [TIME_W-1:0] near_reg, near_next;
    logic [DIFF_W-1:0]        mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [DIV_DEN_W-1:0]     p_reg, p_next;
    logic [DIV_NUM_W-1:0]     num2_reg, num2_next;
    logic [DIV_NUM_W-1:0]     step_reg, step_next;
    logic signed [TIME_W-1:0] res_reg, res_next;
    snap_mode_t               mode_reg, mode_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [TIME_W-1:0] out_pos_reg, out_pos_next;
    snap_mode_t               out_mode_reg, out_mode_next;

    // control signals
    logic                     item_accept;
    logic                     out_load;
    logic                     ram_wr_en;
    logic                     ram_rd_en;
    logic [ADDR_W-1:0]        ram_rd_addr;
    logic signed [TIME_W-1:0] ram_rd_data;
    logic                     div_start;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    // derived values
    logic [CNT_W-1:0]         n_cur;
    logic [CNT_W:0]           mid_sum;
    logic [CNT_W-1:0]         mid_calc;
    logic [DIV_NUM_W-1:0]     num2_calc;
    logic signed [DIFF_W-1:0] diff_g;
    logic signed [DIFF_W-1:0] diff_n;
    logic signed [DIFF_W-1:0] diff_p;
    logic [DIFF_W-1:0]        abs_n;
    logic [DIFF_W-1:0]        abs_p;
    logic signed [SUM_W-1:0]  step_s;
    logic signed [SUM_W-1:0]  grid_sum;

    assign item_accept = item_valid && !item_stall;
    assign cfg_ready   = 1'b1;

    // effective beat count, clamped to the table depth
    assign n_cur = (32'(bcount_reg) > 32'(BEAT_DEPTH)) ? CNT_W'(BEAT_DEPTH) : CNT_W'(bcount_reg);

    // search midpoint
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[CNT_W:1];

    // grid arithmetic
    assign diff_g    = DIFF_W'(pos_reg) - DIFF_W'(offset_reg);
    assign num2_calc = DIV_NUM_W'({mag_reg, 1'b0}) + DIV_NUM_W'(p_reg);
    assign step_s    = $signed({1'b0, step_reg});
    assign grid_sum  = neg_reg ? (SUM_W'(offset_reg) - step_s) : (SUM_W'(offset_reg) + step_s);

    // neighbour distances
    assign diff_n = DIFF_W'(near_reg) - DIFF_W'(pos_reg);
    assign diff_p = DIFF_W'(ram_rd_data) - DIFF_W'(pos_reg);
    assign abs_n  = diff_n[DIFF_W-1] ? DIFF_W'(-diff_n) : DIFF_W'(diff_n);
    assign abs_p  = diff_p[DIFF_W-1] ? DIFF_W'(-diff_p) : DIFF_W'(diff_p);

    // beat table
    bqs_ram #(
        .WIDTH (TIME_W),
        .DEPTH (BEAT_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(entry_index)),
        .wr_data (entry_time),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // shared divider for beat period and grid rounding
    bqs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept && (cmd == CMD_SNAP))
                begin
                    priority if (!quant_en_reg)
                        state_next = ST_DONE;
                    else if (n_cur >= CNT_W'(2))
                        state_next = ST_S_ADDR;
                    else if (tempo_reg == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_G_PER;
                end
            end
            ST_S_ADDR:  state_next = (lo_reg < hi_reg) ? ST_S_CMP : ST_F_RD1;
            ST_S_CMP:   state_next = ST_S_ADDR;
            ST_F_RD1:   state_next = ST_F_RD2;
            ST_F_RD2:   state_next = single_reg ? ST_DONE : ST_F_CMP;
            ST_F_CMP:   state_next = ST_DONE;
            ST_G_PER:   state_next = ST_G_PWAIT;
            ST_G_PWAIT: state_next = div_rsp.done ? ST_G_QUO : ST_G_PWAIT;
            ST_G_QUO:   state_next = ST_G_QWAIT;
            ST_G_QWAIT: state_next = div_rsp.done ? ST_G_SUM : ST_G_QWAIT;
            ST_G_SUM:   state_next = ST_DONE;
            ST_DONE:    state_next = out_load ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        item_stall  = 1'b1;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = lo_reg[ADDR_W-1:0];
        div_start   = 1'b0;
        div_req.num = num2_calc;
        div_req.den = DIV_DEN_W'({p_reg, 1'b0});
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                ram_wr_en  = item_valid && (cmd == CMD_WRITE)
                             && (32'(entry_index) < 32'(BEAT_DEPTH));
            end
            ST_S_ADDR:
            begin
                ram_rd_en   = (lo_reg < hi_reg);
                ram_rd_addr = mid_calc[ADDR_W-1:0];
            end
            ST_F_RD1:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = (lo_reg >= n_reg) ? ADDR_W'(n_reg - 1'b1) : lo_reg[ADDR_W-1:0];
            end
            ST_F_RD2:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ADDR_W'(lo_reg - 1'b1);
            end
            ST_G_PER:
            begin
                div_start   = 1'b1;
                div_req.num = PERIOD_NUM2 + DIV_NUM_W'(tempo_reg);
                div_req.den = DIV_DEN_W'({tempo_reg, 1'b0});
            end
            ST_G_QUO:
            begin
                div_start = 1'b1;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || !result_stall;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        pos_next    = pos_reg;
        n_next      = n_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        single_next = single_reg;
        near_next   = near_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        p_next      = p_reg;
        num2_next   = num2_reg;
        step_next   = step_reg;
        res_next    = res_reg;
        mode_next   = mode_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                pos_next = position;
                n_next   = n_cur;
                lo_next  = '0;
                hi_next  = n_cur;
                res_next = position;
                priority if (!quant_en_reg)
                    mode_next = MODE_OFF;
                else if (n_cur >= CNT_W'(2))
                    mode_next = MODE_TABLE;
                else if (tempo_reg == '0)
                    mode_next = MODE_NO_TEMPO;
                else
                    mode_next = MODE_GRID;
            end
            ST_S_ADDR:
            begin
                mid_next = mid_calc[ADDR_W-1:0];
            end
            ST_S_CMP:
            begin
                // lower bound step
                if (ram_rd_data < pos_reg)
                    lo_next = CNT_W'(mid_reg) + 1'b1;
                else
                    hi_next = CNT_W'(mid_reg);
            end
            ST_F_RD1:
            begin
                single_next = (lo_reg >= n_reg) || (lo_reg == '0);
            end
            ST_F_RD2:
            begin
                near_next = ram_rd_data;
                res_next  = ram_rd_data;
            end
            ST_F_CMP:
            begin
                // tie goes to the earlier beat
                res_next = (abs_n < abs_p) ? near_reg : ram_rd_data;
            end
            ST_G_PER:
            begin
                neg_next = diff_g[DIFF_W-1];
                mag_next = diff_g[DIFF_W-1] ? DIFF_W'(-diff_g) : DIFF_W'(diff_g);
            end
            ST_G_PWAIT:
            begin
                if (div_rsp.done)
                    p_next = div_rsp.quo[DIV_DEN_W-1:0];
            end
            ST_G_QUO:
            begin
                num2_next = num2_calc;
            end
            ST_G_QWAIT:
            begin
                // k * 2p = (2|d| + p) - remainder, halved gives k * p
                if (div_rsp.done)
                    step_next = (num2_reg - DIV_NUM_W'(div_rsp.rem)) >> 1;
            end
            ST_G_SUM:
            begin
                priority if (grid_sum > SUM_W'(32'sh7FFF_FFFF))
                    res_next = 32'sh7FFF_FFFF;
                else if (grid_sum < -SUM_W'(64'sh8000_0000))
                    res_next = 32'sh8000_0000;
                else
                    res_next = TIME_W'(grid_sum);
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        out_pos_next   = out_pos_reg;
        out_mode_next  = out_mode_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_pos_next   = res_reg;
            out_mode_next  = mode_reg;
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            quant_en_reg  <= 1'b0;
            tempo_reg     <= '0;
            offset_reg    <= '0;
            bcount_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_QUANTIZE_ENABLE: quant_en_reg <= cfg_data[0];
                    CFG_TEMPO_BPM:       tempo_reg    <= cfg_data[TEMPO_W-1:0];
                    CFG_GRID_OFFSET:     offset_reg   <= $signed(cfg_data[TIME_W-1:0]);
                    CFG_BEAT_COUNT:      bcount_reg   <= cfg_data[BCNT_W-1:0];
                    default:             bcount_reg   <= bcount_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        n_reg       <= n_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        single_reg  <= single_next;
        near_reg    <= near_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        p_reg       <= p_next;
        num2_reg    <= num2_next;
        step_reg    <= step_next;
        res_reg     <= res_next;
        mode_reg    <= mode_next;
        out_pos_reg <= out_pos_next;
        out_mode_reg <= out_mode_next;
    end

    assign result_valid     = out_valid_reg;
    assign snapped_position = out_pos_reg;
    assign snap_mode        = out_mode_reg;

endmodule
